/* rtl/core/refcounted_slot_table_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the slot table
// Implication checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_SLOT_TABLE_MACROS_SVH
`define REFCOUNTED_SLOT_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define RST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define RST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RST_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/rst_pkg.sv */
// ----------------------------------------------------------------------------
// rst_pkg
// Constants and types for the reference-counted slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package rst_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W    = 5;
  localparam int FUNC_W  = 3;
  localparam int HASH_W  = 64;
  localparam int SIZE_W  = 32;
  localparam int COUNT_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FIND  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FINDI = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REL   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CLR   = 3'd5;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/refcounted_slot_table.sv */
// ----------------------------------------------------------------------------
// refcounted_slot_table
// Table of reference-counted slots keyed by hash and size.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_*: one transaction per table operation. in_tuser holds
//    the operation code, in_tdata the slot id, key hash and key size.
//  - Output channel out_*: exactly one result transaction per operation,
//    in order. out_tuser carries the hit and freed flags, out_tdata the slot
//    id and the reference count after the operation.
//  - Items are processed one at a time. Allocate, clear all and bad ids are
//    done at decode; get and release first read the named slot; finds walk
//    the slot memory one entry per cycle up to the first match or the last
//    slot, as the slot memory has a single read port.
//  - The result sits in an output register; the next transaction is taken as
//    soon as the sequencer is back in idle, while that result still waits.
//    If the receiver stalls with the output register full, the following
//    result is held in the sequencer and input stalls behind it.
//  - Reset (rst_n low, synchronous) clears all used marks at once; no
//    clearing pass is needed, the payload of slots not marked used is ignored.
// ----------------------------------------------------------------------------
`default_nettype none
`include "refcounted_slot_table_macros.svh"

module refcounted_slot_table
  import rst_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,   // [4:0] slot_id, [68:5] key_hash, [100:69] key_size
  input  wire logic [2:0]   in_tuser,   // [2:0] func
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [23:0]       out_tdata,  // [4:0] slot_out, [20:5] count_out
  output logic [1:0]        out_tuser   // [0] hit, [1] freed
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a transaction
  localparam logic [2:0] S_EXEC = 3'd1;  // decode, allocate and clear all, first read
  localparam logic [2:0] S_WAIT = 3'd2;  // read of named slot in flight
  localparam logic [2:0] S_CHK  = 3'd3;  // named slot data available
  localparam logic [2:0] S_SCAN = 3'd4;  // search walk, one entry a cycle
  localparam logic [2:0] S_OUT  = 3'd5;  // hand result to output register

  logic [2:0]         state_r, state_nxt;

  // latched request
  logic [FUNC_W-1:0]  func_r;
  logic [ID_W-1:0]    id_r;
  logic [HASH_W-1:0]  hash_r;
  logic [SIZE_W-1:0]  size_r;

  // slot store: used marks in flops, payload in a memory
  logic [SLOTS-1:0]   used_r, used_nxt;
  entry_t             mem [SLOTS];
  entry_t             rd_data_r;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  // walk pointer / addressed slot
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  // pending result
  logic               res_hit_r, res_hit_nxt;
  logic               res_freed_r, res_freed_nxt;
  logic [ID_W-1:0]    res_slot_r, res_slot_nxt;
  logic [COUNT_W-1:0] res_count_r, res_count_nxt;

  // output register
  logic               out_valid_r;
  logic               out_hit_r, out_freed_r;
  logic [ID_W-1:0]    out_slot_r;
  logic [COUNT_W-1:0] out_count_r;

  // derived decode
  logic               id_ok;
  logic [IDX_W-1:0]   id_idx;
  logic               any_free;
  logic [IDX_W-1:0]   free_idx;
  logic               scan_match;
  logic [ID_W-1:0]    idx_id;
  logic               in_acc;
  logic               out_load;

  assign in_acc   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  assign id_ok  = (id_r != '0) && (32'(id_r) <= SLOTS);
  assign id_idx = IDX_W'(32'(id_r) - 32'd1);
  assign idx_id = ID_W'(32'(idx_r) + 32'd1);   // id is index plus one, fits in 5 bits

  // lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign scan_match = used_r[idx_r] && (rd_data_r.hash == hash_r) &&
                      ((func_r != FUNC_FINDI) || (rd_data_r.size == size_r));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    res_hit_nxt   = res_hit_r;
    res_freed_nxt = res_freed_r;
    res_slot_nxt  = res_slot_r;
    res_count_nxt = res_count_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // default: miss / no-op result
        res_hit_nxt   = 1'b0;
        res_freed_nxt = 1'b0;
        res_slot_nxt  = '0;
        res_count_nxt = '0;
        state_nxt     = S_OUT;
        unique case (func_r)
          FUNC_ALLOC: begin
            if (any_free) begin
              wr_en              = 1'b1;
              wr_addr            = free_idx;
              wr_data.hash       = hash_r;
              wr_data.size       = size_r;
              wr_data.count      = COUNT_W'(1);
              used_nxt[free_idx] = 1'b1;
              res_hit_nxt        = 1'b1;
              res_slot_nxt       = ID_W'(32'(free_idx) + 32'd1);
              res_count_nxt      = COUNT_W'(1);
            end
          end
          FUNC_GET, FUNC_REL: begin
            if (id_ok && used_r[id_idx]) begin
              rd_en     = 1'b1;
              rd_addr   = id_idx;
              idx_nxt   = id_idx;
              state_nxt = S_WAIT;
            end
          end
          FUNC_FIND, FUNC_FINDI: begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            idx_nxt   = '0;
            state_nxt = S_SCAN;
          end
          FUNC_CLR: begin
            used_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_WAIT: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        res_hit_nxt  = 1'b1;
        res_slot_nxt = id_r;
        state_nxt    = S_OUT;
        if (func_r == FUNC_REL) begin
          if (rd_data_r.count > COUNT_W'(1)) begin
            wr_en         = 1'b1;
            wr_data.count = rd_data_r.count - COUNT_W'(1);
            res_count_nxt = rd_data_r.count - COUNT_W'(1);
          end else begin
            // last reference: slot freed, stale payload is ignored while unused
            used_nxt[idx_r] = 1'b0;
            res_count_nxt   = '0;
            res_freed_nxt   = 1'b1;
          end
        end else begin
          res_count_nxt = rd_data_r.count;
        end
      end
      S_SCAN: begin
        if (scan_match) begin
          res_hit_nxt  = 1'b1;
          res_slot_nxt = idx_id;
          state_nxt    = S_OUT;
          if ((func_r == FUNC_FINDI) && (rd_data_r.count != '1)) begin
            wr_en         = 1'b1;
            wr_data.count = rd_data_r.count + COUNT_W'(1);
            res_count_nxt = rd_data_r.count + COUNT_W'(1);
          end else begin
            res_count_nxt = rd_data_r.count;
          end
        end else if (32'(idx_r) == SLOTS - 1) begin
          state_nxt = S_OUT;   // miss, result already zero
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          rd_en   = 1'b1;
          rd_addr = idx_r + IDX_W'(1);
        end
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_tuser;
      id_r   <= in_tdata[4:0];
      hash_r <= in_tdata[68:5];
      size_r <= in_tdata[100:69];
    end
    idx_r       <= idx_nxt;
    res_hit_r   <= res_hit_nxt;
    res_freed_r <= res_freed_nxt;
    res_slot_r  <= res_slot_nxt;
    res_count_r <= res_count_nxt;
    if (out_load) begin
      out_hit_r   <= res_hit_r;
      out_freed_r <= res_freed_r;
      out_slot_r  <= res_slot_r;
      out_count_r <= res_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_slot_r};
  assign out_tuser  = {out_freed_r, out_hit_r};

  // checks
  `RST_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_acc, state_r == S_EXEC)
  `RST_ASSERT_NEXT(a_clear_all_empties, clk, rst_n,
    (state_r == S_EXEC) && (func_r == FUNC_CLR), used_r == '0)
  `RST_ASSERT_NOW(a_miss_is_zero, clk, rst_n, out_valid_r && !out_hit_r,
    (out_slot_r == '0) && (out_count_r == '0) && !out_freed_r)
  `RST_ASSERT_NOW(a_freed_releases, clk, rst_n,
    (state_r == S_CHK) && (func_r == FUNC_REL) && (rd_data_r.count <= COUNT_W'(1)),
    !used_nxt[idx_r])

endmodule

`default_nettype wire
